// ----- sv/vertex_transform_project_defines.svh -----
// Assertion macros for the vertex transform block.
// Included by files that carry concurrent checks.
`ifndef VERTEX_TRANSFORM_PROJECT_DEFINES_SVH
`define VERTEX_TRANSFORM_PROJECT_DEFINES_SVH
`ifndef ASSERT_OFF
`define VTP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define VTP_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define VTP_ASSERT(label, clk, rst_n, prop)
`define VTP_ASSERT_RST(label, clk, prop)
`endif
`endif

// ----- sv/vtp_pkg.sv -----
// Shared types and constants for the vertex transform block.
// No dependencies.
package vtp_pkg;
    localparam int COEFF_FRAC_BITS = 12;
    localparam int VEC_FRAC_BITS   = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int DIV_STAGES      = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0    = 3'd0,
        REG_ROW1    = 3'd1,
        REG_ROW2    = 3'd2,
        REG_ROW3    = 3'd3,
        REG_DIV_EN  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic signed [31:0] in_w;
    } t_vtx_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic               w_is_zero;
        logic               saturated;
    } t_vtx_out;

    // Front-to-back item: transformed values and divide decision.
    typedef struct packed {
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic signed [31:0] r_w;
        logic               do_div;
        logic               w_zero;
        logic               sat;
    } t_xf_item;
endpackage

// ----- sv/vtp_front.sv -----
// Front part: matrix-vector product, floor shift, saturation, classification.
// Depends on vtp_pkg. Three register stages: products, row sums, clamp.
module vtp_front #(
    parameter int COEFF_FRAC = vtp_pkg::COEFF_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  vtp_pkg::t_vtx_in  i_vtx,
    input  logic [255:0]      i_mat,
    input  logic              i_div_en,
    output logic              o_valid,
    output vtp_pkg::t_xf_item o_item
);
    logic signed [47:0] r_prod [16];
    logic signed [49:0] r_sum  [4];
    logic [2:0]         r_vld;
    logic               r_div_en1, r_div_en2;
    logic signed [31:0] w_vec [4];
    logic signed [31:0] w_clamp [4];
    logic [3:0]         w_sat;

    assign w_vec[0] = i_vtx.in_x;
    assign w_vec[1] = i_vtx.in_y;
    assign w_vec[2] = i_vtx.in_z;
    assign w_vec[3] = i_vtx.in_w;

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                r_prod[r*4+c] <= $signed(i_mat[r*64+c*16 +: 16]) * w_vec[c];
            end
            r_sum[r] <= 50'(r_prod[r*4]) + 50'(r_prod[r*4+1])
                      + 50'(r_prod[r*4+2]) + 50'(r_prod[r*4+3]);
        end
        r_div_en1 <= i_div_en;
        r_div_en2 <= r_div_en1;
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            logic signed [49:0] sh;
            sh = r_sum[r] >>> COEFF_FRAC;
            if (sh > 50'sd2147483647) begin
                w_clamp[r] = 32'sh7FFFFFFF;
                w_sat[r]   = 1'b1;
            end else if (sh < -50'sd2147483648) begin
                w_clamp[r] = 32'sh80000000;
                w_sat[r]   = 1'b1;
            end else begin
                w_clamp[r] = sh[31:0];
                w_sat[r]   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
        o_item.r_x    <= w_clamp[0];
        o_item.r_y    <= w_clamp[1];
        o_item.r_z    <= w_clamp[2];
        o_item.r_w    <= w_clamp[3];
        o_item.w_zero <= r_div_en2 && (w_clamp[3] == 32'sd0);
        o_item.do_div <= r_div_en2 && (w_clamp[3] != 32'sd0);
        o_item.sat    <= |w_sat;
    end

    assign o_valid = r_vld[2];
endmodule

// ----- sv/vtp_fifo.sv -----
// Short queue between the transform front and the divide back.
// Depends on vtp_pkg.
module vtp_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  vtp_pkg::t_xf_item i_data,
    input  logic              i_pop,
    output logic              o_empty,
    output vtp_pkg::t_xf_item o_data
);
    localparam int AW = $clog2(DEPTH);
    vtp_pkg::t_xf_item r_mem [DEPTH];
    logic [AW:0] r_wp, r_rp;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp[AW-1:0]] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    assign o_empty = (r_wp == r_rp);
    assign o_data  = r_mem[r_rp[AW-1:0]];
endmodule

// ----- sv/vtp_back.sv -----
// Back part: pipelined restoring divide of x, y, z by w, one quotient bit a stage.
// Depends on vtp_pkg.
module vtp_back #(
    parameter int VEC_FRAC = vtp_pkg::VEC_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  vtp_pkg::t_xf_item i_item,
    output logic              o_valid,
    output vtp_pkg::t_vtx_out o_res
);
    localparam int NW = 32 + VEC_FRAC;
    localparam int NS = NW;

    typedef struct packed {
        logic [NW-1:0] num0, num1, num2;
        logic [NW-1:0] rem0, rem1, rem2;
        logic [31:0]   dmag;
        logic [2:0]    neg;
        logic signed [31:0] x, y, z, w;
        logic          do_div, w_zero, sat;
    } t_dstage;

    t_dstage       w_st0;
    logic          w_vld0;
    t_dstage       r_st [NS];
    logic [NS-1:0] r_vld;

    function automatic logic [NW-1:0] f_mag(input logic signed [31:0] v);
        logic [32:0] m;
        m = v[31] ? -{v[31], v} : {1'b0, v};
        return NW'(m) << VEC_FRAC;
    endfunction

    function automatic logic [NW-1:0] f_shift(input logic [NW-1:0] n);
        return n << 1;
    endfunction

    always_comb begin
        w_st0.num0   = f_mag(i_item.r_x);
        w_st0.num1   = f_mag(i_item.r_y);
        w_st0.num2   = f_mag(i_item.r_z);
        w_st0.rem0   = '0;
        w_st0.rem1   = '0;
        w_st0.rem2   = '0;
        w_st0.dmag   = i_item.r_w[31] ? 32'(-{i_item.r_w[31], i_item.r_w})
                                     : i_item.r_w;
        w_st0.neg    = {i_item.r_z[31] ^ i_item.r_w[31],
                        i_item.r_y[31] ^ i_item.r_w[31],
                        i_item.r_x[31] ^ i_item.r_w[31]};
        w_st0.x      = i_item.r_x;
        w_st0.y      = i_item.r_y;
        w_st0.z      = i_item.r_z;
        w_st0.w      = i_item.r_w;
        w_st0.do_div = i_item.do_div;
        w_st0.w_zero = i_item.w_zero;
        w_st0.sat    = i_item.sat;
        w_vld0       = i_valid;
    end

    // Each stage brings in one numerator bit and subtracts the divisor if it fits.
    for (genvar s = 0; s < NS; s++) begin : g_div
        t_dstage     w_cur;
        logic        w_cur_vld;
        t_dstage     n_st;
        logic [NW:0] w_dvs;
        logic [NW:0] t0, t1, t2;
        if (s == 0) begin : g_first
            assign w_cur     = w_st0;
            assign w_cur_vld = w_vld0;
        end else begin : g_next
            assign w_cur     = r_st[s-1];
            assign w_cur_vld = r_vld[s-1];
        end
        assign w_dvs = (NW+1)'(w_cur.dmag);
        assign t0 = {w_cur.rem0, w_cur.num0[NW-1]};
        assign t1 = {w_cur.rem1, w_cur.num1[NW-1]};
        assign t2 = {w_cur.rem2, w_cur.num2[NW-1]};
        always_comb begin
            n_st      = w_cur;
            n_st.rem0 = (t0 >= w_dvs) ? NW'(t0 - w_dvs) : NW'(t0);
            n_st.rem1 = (t1 >= w_dvs) ? NW'(t1 - w_dvs) : NW'(t1);
            n_st.rem2 = (t2 >= w_dvs) ? NW'(t2 - w_dvs) : NW'(t2);
            n_st.num0 = f_shift(w_cur.num0) | NW'(t0 >= w_dvs);
            n_st.num1 = f_shift(w_cur.num1) | NW'(t1 >= w_dvs);
            n_st.num2 = f_shift(w_cur.num2) | NW'(t2 >= w_dvs);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= w_cur_vld;
            end
            r_st[s] <= n_st;
        end
    end

    // Quotient magnitude sits in num after the last stage; apply sign and clamp.
    function automatic logic [32:0] f_fix(input logic [NW-1:0] q, input logic neg);
        logic [32:0] res;
        logic        sat;
        sat = 1'b0;
        if (neg) begin
            if (q > NW'(64'h80000000)) begin
                res = 33'h80000000;
                sat = 1'b1;
            end else begin
                res = {1'b0, 32'(-q)};
            end
        end else begin
            if (q > NW'(64'h7FFFFFFF)) begin
                res = 33'h7FFFFFFF;
                sat = 1'b1;
            end else begin
                res = {1'b0, q[31:0]};
            end
        end
        res[32] = sat;
        return res;
    endfunction

    logic [32:0] w_q0, w_q1, w_q2;
    assign w_q0 = f_fix(r_st[NS-1].num0, r_st[NS-1].neg[0]);
    assign w_q1 = f_fix(r_st[NS-1].num1, r_st[NS-1].neg[1]);
    assign w_q2 = f_fix(r_st[NS-1].num2, r_st[NS-1].neg[2]);

    logic r_out_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[NS-1];
        end
        o_res.out_w     <= r_st[NS-1].w;
        o_res.w_is_zero <= r_st[NS-1].w_zero;
        if (r_st[NS-1].do_div) begin
            o_res.out_x     <= w_q0[31:0];
            o_res.out_y     <= w_q1[31:0];
            o_res.out_z     <= w_q2[31:0];
            o_res.saturated <= r_st[NS-1].sat | w_q0[32] | w_q1[32] | w_q2[32];
        end else begin
            o_res.out_x     <= r_st[NS-1].x;
            o_res.out_y     <= r_st[NS-1].y;
            o_res.out_z     <= r_st[NS-1].z;
            o_res.saturated <= r_st[NS-1].sat;
        end
    end
    assign o_valid = r_out_vld;
endmodule

// ----- sv/vertex_transform_project.sv -----
// Top level of the vertex transform: config registers, front, queue, back.
// Depends on vtp_pkg, vtp_front, vtp_fifo, vtp_back and the defines header.
//
//  channel   direction  handshake            payload
//  vertex    in         i_start & !o_busy    i_vtx (t_vtx_in)
//  result    out        o_done strobe        o_res (t_vtx_out)
//  config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One vertex per cycle; o_busy stays low. A vertex passes 3 transform stages,
// one queue register, VEC_FRAC_BITS+32 divide stages and one output register.
// Reset (synchronous, active low) restores the identity matrix, divide on,
// and empties the pipeline. The receiver cannot stall; results never wait.
`include "vertex_transform_project_defines.svh"
module vertex_transform_project #(
    parameter int COEFF_FRAC_BITS = vtp_pkg::COEFF_FRAC_BITS,
    parameter int VEC_FRAC_BITS   = vtp_pkg::VEC_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  vtp_pkg::t_vtx_in                  i_vtx,
    output logic                              o_done,
    output vtp_pkg::t_vtx_out                 o_res,
    input  logic                              i_cfg_we,
    input  logic [vtp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [vtp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    logic [255:0] r_mat;
    logic         r_div_en;
    logic         w_fv, w_empty, w_bv;
    vtp_pkg::t_xf_item w_fitem, w_qitem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat    <= {64'h1000000000000000, 64'h0000100000000000,
                         64'h0000000010000000, 64'h0000000000001000};
            r_div_en <= 1'b1;
        end else if (i_cfg_we) begin
            case (vtp_pkg::t_cfg_idx'(i_cfg_idx))
                vtp_pkg::REG_ROW0:   r_mat[63:0]    <= i_cfg_data;
                vtp_pkg::REG_ROW1:   r_mat[127:64]  <= i_cfg_data;
                vtp_pkg::REG_ROW2:   r_mat[191:128] <= i_cfg_data;
                vtp_pkg::REG_ROW3:   r_mat[255:192] <= i_cfg_data;
                vtp_pkg::REG_DIV_EN: r_div_en       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    vtp_front #(.COEFF_FRAC(COEFF_FRAC_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid(i_start & ~o_busy), .i_vtx,
        .i_mat(r_mat), .i_div_en(r_div_en), .o_valid(w_fv), .o_item(w_fitem)
    );

    // Back never stalls, so pop whatever is at the head.
    vtp_fifo #(.DEPTH(4)) u_fifo (
        .i_clk, .i_rst_n, .i_push(w_fv), .i_data(w_fitem),
        .i_pop(!w_empty), .o_empty(w_empty), .o_data(w_qitem)
    );

    assign w_bv = !w_empty;

    vtp_back #(.VEC_FRAC(VEC_FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_bv), .i_item(w_qitem),
        .o_valid(o_done), .o_res
    );

    `VTP_ASSERT(a_wz_excl, i_clk, i_rst_n, o_done |-> !(o_res.w_is_zero && o_res.out_w != 32'sd0))
    `VTP_ASSERT(a_item_cls, i_clk, i_rst_n, w_fv |-> !(w_fitem.do_div && w_fitem.w_zero))
    `VTP_ASSERT_RST(a_rst_quiet, i_clk, !i_rst_n |=> !o_done)
endmodule
